// ----- rtl/lzw_byte_compressor_core_assert.svh -----
// Assertion macros used by the LZW compressor core.
`ifndef LZW_BYTE_COMPRESSOR_CORE_ASSERT_SVH
`define LZW_BYTE_COMPRESSOR_CORE_ASSERT_SVH

// expr must never hold at a clock edge outside reset
`define LZWBC_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// when ante holds, cons must hold in the next cycle
`define LZWBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lzwbc_pkg.sv -----
// Types, constants and state encoding for the LZW byte compressor.
package lzwbc_pkg;

    localparam int CODE_BITS     = 16;
    localparam int TABLE_ENTRIES = 65536;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int EPOCH_W       = 8;
    localparam int KEY_W         = 24;
    localparam int HASH_W        = 8 + IDX_W;
    localparam int OUT_W         = 16;

    typedef logic [CODE_BITS-1:0] code_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [EPOCH_W-1:0]   epoch_t;

    localparam logic [31:0] HASH_MULT  = 32'h9E3779B1;
    localparam code_t       CODE_CEIL  = '1;
    localparam code_t       FIRST_FREE = CODE_BITS'(256);
    localparam epoch_t      EPOCH_LAST = '1;
    localparam epoch_t      EPOCH_EMPTY = '0;
    localparam epoch_t      EPOCH_FIRST = EPOCH_W'(1);
    localparam idx_t        IDX_LAST   = '1;

    // one string table entry; epoch tags the stream that wrote it
    typedef struct packed {
        epoch_t     epoch;
        code_t      prefix;
        logic [7:0] byte_val;
        code_t      code;
    } tab_entry_t;

    localparam int ENTRY_W = $bits(tab_entry_t);

    typedef struct packed {
        logic mix_en;
        logic mul_en;
    } hash_ctl_t;

    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] code;
        logic             last;
    } push_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MIX,
        S_MUL,
        S_PROBE,
        S_CMP,
        S_PUSH_MISS,
        S_PUSH_EOS
    } state_t;

endpackage

// ----- rtl/lzwbc_ram.sv -----
// Generic simple dual-port RAM with registered read.
module lzwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/lzwbc_hash.sv -----
// Two-stage slot hash: xor-shift mix, then truncated multiply.
module lzwbc_hash (
    input  logic                 clk,
    input  lzwbc_pkg::hash_ctl_t ctl,
    input  lzwbc_pkg::code_t     prefix,
    input  logic [7:0]           byte_val,
    output lzwbc_pkg::idx_t      slot
);
    import lzwbc_pkg::*;

    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  mix;
    logic [HASH_W-1:0] mix_reg;
    logic [HASH_W-1:0] prod;
    idx_t              slot_reg;

    // key = prefix:byte, prefix zero-extended to 24 bits
    always_comb
    begin
        key = (KEY_W'(prefix) << 8) | KEY_W'(byte_val);
        mix = key ^ (key >> 11);
    end

    // the product is cut to HASH_W bits; its upper IDX_W bits form the slot index
    assign prod = mix_reg * HASH_MULT[HASH_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.mix_en)
        begin
            mix_reg <= mix[HASH_W-1:0];
        end
        if (ctl.mul_en)
        begin
            slot_reg <= prod[HASH_W-1:8];
        end
    end

    assign slot = slot_reg;

endmodule

// ----- rtl/lzwbc_out_stage.sv -----
// Output register for emitted codes, decoupling the core from the sink.
module lzwbc_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lzwbc_pkg::push_t            push,
    output logic                        free,
    output logic                        code_valid,
    input  logic                        code_ready,
    output logic [lzwbc_pkg::OUT_W-1:0] code_word,
    output logic                        last_code
);
    import lzwbc_pkg::*;

    logic             valid_reg;
    logic [OUT_W-1:0] code_reg;
    logic             last_reg;

    assign free = !valid_reg || code_ready;

    // control: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (code_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            code_reg <= push.code;
            last_reg <= push.last;
        end
    end

    assign code_valid = valid_reg;
    assign code_word  = code_reg;
    assign last_code  = last_reg;

endmodule

// ----- rtl/lzw_byte_compressor_core.sv -----
// LZW byte compressor with fixed 16-bit codes. A byte that opens a stream
// loads the prefix without a lookup; every later byte runs a hashed lookup in
// the string table RAM: mix, multiply, first read, then one more read per
// collision along the linear probe chain. Every emitted code is pushed to the
// output stage in a separate push state, which stalls while the output
// register is still full. The string table tags entries with a stream epoch,
// so ending a stream clears it at once; after reset, and after every 255th
// stream when the epoch wraps, a clearing pass writes all 65536 entries, one
// per cycle, during which no byte is accepted.
`include "lzw_byte_compressor_core_assert.svh"

module lzw_byte_compressor_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        data_valid,
    output logic                        data_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_stream,
    output logic                        code_valid,
    input  logic                        code_ready,
    output logic [lzwbc_pkg::OUT_W-1:0] code_word,
    output logic                        last_code
);
    import lzwbc_pkg::*;

    state_t     state_reg, state_next;
    code_t      prefix_reg, prefix_next;
    logic       prefix_valid_reg, prefix_valid_next;
    code_t      next_free_reg, next_free_next;
    epoch_t     epoch_reg, epoch_next;
    idx_t       clr_cnt_reg, clr_cnt_next;
    idx_t       probe_addr_reg, probe_addr_next;
    idx_t       probe_cnt_reg, probe_cnt_next;
    code_t      emit_reg, emit_next;
    logic [7:0] byte_reg, byte_next;
    logic       eos_reg, eos_next;

    hash_ctl_t  hash_ctl;
    idx_t       hash_slot;
    push_t      push;
    logic       out_free;

    logic       wr_en;
    idx_t       wr_addr;
    tab_entry_t wr_entry;
    logic       rd_en;
    idx_t       rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    tab_entry_t rd_entry;

    logic       accept;
    logic       slot_empty;
    logic       slot_match;
    logic       probe_done;

    assign accept   = data_valid && data_ready;
    assign rd_entry = tab_entry_t'(rd_data);

    // lookup outcome for the slot read last cycle
    always_comb
    begin
        slot_empty = rd_entry.epoch != epoch_reg;
        slot_match = !slot_empty && rd_entry.prefix == prefix_reg
                     && rd_entry.byte_val == byte_reg;
        probe_done = probe_cnt_reg == IDX_LAST;
    end

    lzwbc_hash u_hash (
        .clk      (clk),
        .ctl      (hash_ctl),
        .prefix   (prefix_reg),
        .byte_val (byte_reg),
        .slot     (hash_slot)
    );

    lzwbc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lzwbc_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .free       (out_free),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_word  (code_word),
        .last_code  (last_code)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!prefix_valid_reg)
                    begin
                        state_next = end_of_stream ? S_PUSH_EOS : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MIX;
                    end
                end
            end
            S_MIX:   state_next = S_MUL;
            S_MUL:   state_next = S_PROBE;
            S_PROBE: state_next = S_CMP;
            S_CMP:
            begin
                if (slot_match)
                begin
                    state_next = eos_reg ? S_PUSH_EOS : S_IDLE;
                end
                else if (slot_empty || probe_done)
                begin
                    state_next = S_PUSH_MISS;
                end
            end
            S_PUSH_MISS:
            begin
                if (out_free)
                begin
                    state_next = eos_reg ? S_PUSH_EOS : S_IDLE;
                end
            end
            S_PUSH_EOS:
            begin
                if (out_free)
                begin
                    state_next = (epoch_reg == EPOCH_LAST) ? S_CLEAR : S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        next_free_next    = next_free_reg;
        epoch_next        = epoch_reg;
        clr_cnt_next      = clr_cnt_reg;
        probe_addr_next   = probe_addr_reg;
        probe_cnt_next    = probe_cnt_reg;
        emit_next         = emit_reg;
        byte_next         = byte_reg;
        eos_next          = eos_reg;
        data_ready        = 1'b0;
        hash_ctl          = '0;
        push              = '0;
        wr_en             = 1'b0;
        wr_addr           = probe_addr_reg;
        wr_entry          = '0;
        rd_en             = 1'b0;
        rd_addr           = hash_slot;

        unique case (state_reg)
            S_CLEAR:
            begin
                // stamp every entry with the empty epoch
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_entry     = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                data_ready = 1'b1;
                if (accept)
                begin
                    byte_next = data_byte;
                    eos_next  = end_of_stream;
                    if (!prefix_valid_reg)
                    begin
                        prefix_next       = CODE_BITS'(data_byte);
                        prefix_valid_next = 1'b1;
                    end
                end
            end
            S_MIX: hash_ctl.mix_en = 1'b1;
            S_MUL: hash_ctl.mul_en = 1'b1;
            S_PROBE:
            begin
                rd_en           = 1'b1;
                rd_addr         = hash_slot;
                probe_addr_next = hash_slot;
                probe_cnt_next  = '0;
            end
            S_CMP:
            begin
                if (slot_match)
                begin
                    prefix_next = rd_entry.code;
                end
                else if (slot_empty || probe_done)
                begin
                    // miss: emit the prefix, maybe add the pair
                    emit_next   = prefix_reg;
                    prefix_next = CODE_BITS'(byte_reg);
                    if (slot_empty && next_free_reg < CODE_CEIL)
                    begin
                        wr_en             = 1'b1;
                        wr_addr           = probe_addr_reg;
                        wr_entry.epoch    = epoch_reg;
                        wr_entry.prefix   = prefix_reg;
                        wr_entry.byte_val = byte_reg;
                        wr_entry.code     = next_free_reg;
                        next_free_next    = next_free_reg + 1'b1;
                    end
                end
                else
                begin
                    // collision: read the following slot
                    rd_en           = 1'b1;
                    rd_addr         = probe_addr_reg + 1'b1;
                    probe_addr_next = probe_addr_reg + 1'b1;
                    probe_cnt_next  = probe_cnt_reg + 1'b1;
                end
            end
            S_PUSH_MISS:
            begin
                if (out_free)
                begin
                    push.valid = 1'b1;
                    push.code  = OUT_W'(emit_reg);
                    push.last  = 1'b0;
                end
            end
            S_PUSH_EOS:
            begin
                if (out_free)
                begin
                    push.valid        = 1'b1;
                    push.code         = OUT_W'(prefix_reg);
                    push.last         = 1'b1;
                    prefix_next       = '0;
                    prefix_valid_next = 1'b0;
                    next_free_next    = FIRST_FREE;
                    if (epoch_reg == EPOCH_LAST)
                    begin
                        epoch_next   = EPOCH_FIRST;
                        clr_cnt_next = '0;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            next_free_reg    <= FIRST_FREE;
            epoch_reg        <= EPOCH_FIRST;
            clr_cnt_reg      <= '0;
            probe_cnt_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            next_free_reg    <= next_free_next;
            epoch_reg        <= epoch_next;
            clr_cnt_reg      <= clr_cnt_next;
            probe_cnt_reg    <= probe_cnt_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        probe_addr_reg <= probe_addr_next;
        emit_reg       <= emit_next;
        byte_reg       <= byte_next;
        eos_reg        <= eos_next;
    end

    // checks
    `LZWBC_ASSERT_NEVER(a_epoch_nonempty, epoch_reg == EPOCH_EMPTY, "live epoch equals empty tag")
    `LZWBC_ASSERT_NEXT(a_lookup_start, accept && prefix_valid_reg, state_reg == S_MIX, "lookup did not start")
    `LZWBC_ASSERT_NEXT(a_eos_clears, push.valid && push.last, !prefix_valid_reg && next_free_reg == FIRST_FREE, "stream end did not clear state")
    `LZWBC_ASSERT_NEXT(a_insert_bumps, state_reg == S_CMP && wr_en, next_free_reg == code_t'($past(next_free_reg) + 1'b1), "insert without code advance")

endmodule
